### hw/rtl/lpfc_pkg.sv
// ============================================================================
// Length-prefixed frame checker package
// Shared constants, status codes and the frame verdict type.
// ============================================================================
package lpfc_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int POS_WIDTH       = 9;
   localparam int SUM_WIDTH       = 16;
   localparam int CH_LIMIT_WIDTH  = 9;
   localparam int GATEWAY_WIDTH   = 9;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 9;

   localparam logic [POS_WIDTH-1:0]      POS_SAT        = 9'd257;
   localparam logic [POS_WIDTH-1:0]      HEADER_BYTES   = 9'd2;
   localparam logic [GATEWAY_WIDTH-1:0]  GATEWAY_OFFSET = 9'd100;
   localparam logic [GATEWAY_WIDTH-1:0]  GATEWAY_RESET  = 9'd1;
   localparam logic [CH_LIMIT_WIDTH-1:0] CH_LIMIT_RESET = 9'd8;
   localparam logic [BYTE_WIDTH-1:0]     PL_LIMIT_RESET = 8'd64;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHANNEL_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAYLOAD_LIMIT = 2'd1;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_CHANNEL = 2'd1,
      STATUS_BAD_LENGTH  = 2'd2
   } status_type;

   typedef struct packed {
      status_type            status;
      logic [BYTE_WIDTH-1:0] channel;
      logic [BYTE_WIDTH-1:0] length;
      logic [SUM_WIDTH-1:0]  sum;
   } verdict_type;

   typedef struct packed {
      verdict_type              verdict;
      logic [GATEWAY_WIDTH-1:0] gateway;
   } result_type;

endpackage

### hw/rtl/lpfc_frame.sv
// ============================================================================
// Frame tracker
// Holds header bytes, byte position and running sum of the current frame and
// forms the verdict for a request that closes the frame.
// ============================================================================
module lpfc_frame (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  take,
   input  logic [lpfc_pkg::BYTE_WIDTH-1:0]       data_byte,
   input  logic                                  frame_end,
   input  logic [lpfc_pkg::CH_LIMIT_WIDTH-1:0]   channel_limit,
   input  logic [lpfc_pkg::BYTE_WIDTH-1:0]       payload_limit,
   output lpfc_pkg::verdict_type                 verdict
);
   import lpfc_pkg::*;

   logic [POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [BYTE_WIDTH-1:0] channel_ff, channel_in;
   logic [BYTE_WIDTH-1:0] length_ff, length_in;
   logic [SUM_WIDTH-1:0]  sum_ff, sum_in;
   logic                  in_payload;
   logic [POS_WIDTH:0]    needed;

   always_comb begin
      channel_in = (pos_ff == '0) ? data_byte : channel_ff;
      length_in  = (pos_ff == POS_WIDTH'(1)) ? data_byte : length_ff;
      in_payload = (pos_ff >= HEADER_BYTES)
                   && ((pos_ff - HEADER_BYTES) < {1'b0, length_ff});
      sum_in     = in_payload ? sum_ff + SUM_WIDTH'(data_byte) : sum_ff;
      pos_in     = (pos_ff < POS_SAT) ? pos_ff + POS_WIDTH'(1) : POS_SAT;
      needed     = {1'b0, HEADER_BYTES} + {2'b00, length_in};

      verdict.channel = channel_in;
      verdict.length  = length_in;
      verdict.sum     = '0;
      priority if (pos_in < HEADER_BYTES) begin
         verdict.status  = STATUS_BAD_LENGTH;
         verdict.channel = '0;
         verdict.length  = '0;
      end else if ({1'b0, channel_in} >= channel_limit) begin
         verdict.status = STATUS_BAD_CHANNEL;
      end else if (length_in > payload_limit) begin
         verdict.status = STATUS_BAD_LENGTH;
      end else if ({1'b0, pos_in} < needed) begin
         verdict.status = STATUS_BAD_LENGTH;
      end else begin
         verdict.status = STATUS_OK;
         verdict.sum    = sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         channel_ff <= '0;
         length_ff  <= '0;
         sum_ff     <= '0;
      end else if (take) begin
         if (frame_end) begin
            pos_ff     <= '0;
            channel_ff <= '0;
            length_ff  <= '0;
            sum_ff     <= '0;
         end else begin
            pos_ff     <= pos_in;
            channel_ff <= channel_in;
            length_ff  <= length_in;
            sum_ff     <= sum_in;
         end
      end
   end

endmodule

### hw/rtl/length_prefixed_frame_checker_core.sv
// ============================================================================
// Length-prefixed frame checker core
// Checks channel and length header of byte-serial frames, sums the payload
// and reports one result per frame.
// ============================================================================
// One request byte is taken every clock cycle while req_stall is low; the result of a frame is
// registered in the cycle after the request that carries frame_end and shows on
// the response port at once when the output register is free, else behind
// the result that waits there.
// Header capture, the payload add and all status compares sit in one
// combinational step between the frame state registers and the output
// register. A two-entry output (register plus skid) lets requests keep
// flowing while a result waits; req_stall rises only once both entries hold
// results that the consumer has not taken.
module length_prefixed_frame_checker_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [lpfc_pkg::BYTE_WIDTH-1:0]        req_data_byte,
   input  logic                                   req_frame_end,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [1:0]                             rsp_status,
   output logic [lpfc_pkg::BYTE_WIDTH-1:0]        rsp_channel,
   output logic [lpfc_pkg::BYTE_WIDTH-1:0]        rsp_payload_length,
   output logic [lpfc_pkg::SUM_WIDTH-1:0]         rsp_payload_sum,
   output logic [lpfc_pkg::GATEWAY_WIDTH-1:0]     rsp_gateway_value,
   input  logic                                   csr_write,
   input  logic [lpfc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [lpfc_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import lpfc_pkg::*;

   logic [CH_LIMIT_WIDTH-1:0] ch_limit_ff;
   logic [BYTE_WIDTH-1:0]     pl_limit_ff;
   logic [GATEWAY_WIDTH-1:0]  gateway_ff, gateway_in;
   result_type                rsp_ff, skid_ff, result;
   logic                      rsp_valid_ff, skid_valid_ff;
   logic                      req_take, res_push, rsp_pop;
   verdict_type               verdict;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign res_push  = req_take && req_frame_end;
   assign rsp_pop   = rsp_valid_ff && !rsp_stall;

   lpfc_frame u_frame (
      .clock         (clock),
      .reset         (reset),
      .take          (req_take),
      .data_byte     (req_data_byte),
      .frame_end     (req_frame_end),
      .channel_limit (ch_limit_ff),
      .payload_limit (pl_limit_ff),
      .verdict       (verdict)
   );

   always_comb begin
      gateway_in = gateway_ff;
      if (verdict.status == STATUS_OK) begin
         gateway_in = {1'b0, verdict.channel} + GATEWAY_OFFSET;
      end
      result.verdict = verdict;
      result.gateway = gateway_in;
   end

   // hold limits; drop writes beyond the register list
   always_ff @(posedge clock) begin
      if (reset) begin
         ch_limit_ff <= CH_LIMIT_RESET;
         pl_limit_ff <= PL_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CHANNEL_LIMIT: ch_limit_ff <= csr_data;
            CSR_PAYLOAD_LIMIT: pl_limit_ff <= csr_data[BYTE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gateway_ff <= GATEWAY_RESET;
      end else if (res_push) begin
         gateway_ff <= gateway_in;
      end
   end

   // advance output register from skid first, else from a new result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_pop) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= res_push;
         end
      end else if (res_push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_pop) begin
         if (skid_valid_ff) begin
            rsp_ff <= skid_ff;
         end else if (res_push) begin
            rsp_ff <= result;
         end
      end else if (res_push) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.verdict.status;
   assign rsp_channel        = rsp_ff.verdict.channel;
   assign rsp_payload_length = rsp_ff.verdict.length;
   assign rsp_payload_sum    = rsp_ff.verdict.sum;
   assign rsp_gateway_value  = rsp_ff.gateway;

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a result while output register is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (res_push && rsp_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("result lost while output register was stalled");

   a_gateway_change: assert property (@(posedge clock) disable iff (reset)
      !$stable(gateway_ff) |-> $past(res_push && (verdict.status == STATUS_OK)))
      else $error("gateway changed without an ok frame");

endmodule
